/* sv/ebsv_pkg.sv */
// Shared types, constants and lookup functions of the encoder bank scanner.
package ebsv_pkg;

   localparam int NUM_ENC    = 16;
   localparam int SLOT_W     = 4;
   localparam int SCAN_W     = 64;
   localparam int TIME_W     = 32;
   localparam int VALUE_W    = 32;
   localparam int KIND_W     = 2;
   localparam int ELAPSED_W  = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROTATE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MAX = 1'b1;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN_RESET   = 32'sd0;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX_RESET   = 32'sd127;
   localparam logic signed [VALUE_W-1:0] PRESS_VALUE       = 32'sd127;
   localparam logic signed [VALUE_W-1:0] RELEASE_VALUE     = 32'sd0;
   localparam logic [4:0]                VEL_SPAN          = 5'd25;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic load;       // latch a new frame and restart the slot walk
      logic eval;       // look at the current slot, commit it when it changed
      logic push_btn;   // queue the pending button item
      logic push_rot;   // queue the pending rotation item
      logic next_slot;  // advance to the following slot
      logic flush;      // send the held item as the last one of the frame
   } ebsv_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic changed;
      logic btn_pend;
      logic rot_pend;
      logic hold_valid;
      logic can_push;
      logic out_free;
      logic last_slot;
   } ebsv_sts_type;

   // Wiring of scan slots to encoder numbers.
   function automatic logic [SLOT_W-1:0] enc_of_slot(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] enc;
      unique case (slot)
         4'd0:    enc = 4'd14;
         4'd1:    enc = 4'd15;
         4'd2:    enc = 4'd10;
         4'd3:    enc = 4'd11;
         4'd4:    enc = 4'd6;
         4'd5:    enc = 4'd7;
         4'd6:    enc = 4'd2;
         4'd7:    enc = 4'd3;
         4'd8:    enc = 4'd12;
         4'd9:    enc = 4'd13;
         4'd10:   enc = 4'd8;
         4'd11:   enc = 4'd9;
         4'd12:   enc = 4'd4;
         4'd13:   enc = 4'd5;
         4'd14:   enc = 4'd0;
         default: enc = 4'd1;
      endcase
      return enc;
   endfunction

   // Step size 2f-1 with f = (625 - c*c) / 150 + 1, for a clamped time c of 1..25 ms.
   function automatic logic [3:0] vel_step(input logic [4:0] c);
      logic [3:0] mag;
      case (c) inside
         [5'd1:5'd5]:   mag = 4'd9;
         [5'd6:5'd13]:  mag = 4'd7;
         [5'd14:5'd18]: mag = 4'd5;
         [5'd19:5'd21]: mag = 4'd3;
         default:       mag = 4'd1;
      endcase
      return mag;
   endfunction

endpackage

/* sv/ebsv_ctrl.sv */
// Sequencer that walks the sixteen slots of a frame and paces item output.
module ebsv_ctrl import ebsv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ebsv_sts_type sts,
   output ebsv_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_BTN   = 3'd2;
   localparam logic [2:0] S_ROT   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.changed) begin
               state_in = S_BTN;
            end else if (sts.last_slot) begin
               state_in = S_FLUSH;
            end else begin
               cmd.next_slot = 1'b1;
            end
         end
         S_BTN: begin
            if (!sts.btn_pend || sts.can_push) begin
               cmd.push_btn = sts.btn_pend;
               state_in     = S_ROT;
            end
         end
         S_ROT: begin
            if (!sts.rot_pend || sts.can_push) begin
               cmd.push_rot = sts.rot_pend;
               if (sts.last_slot) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.next_slot = 1'b1;
                  state_in      = S_EVAL;
               end
            end
         end
         S_FLUSH: begin
            if (!sts.hold_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/ebsv_dp.sv */
// Datapath: per-encoder state, quadrature and velocity logic, item queue and output register.
module ebsv_dp import ebsv_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ebsv_cmd_type                cmd,
   output ebsv_sts_type                sts,
   input  logic [SCAN_W-1:0]           req_scan_bits,
   input  logic [TIME_W-1:0]           req_now_ms,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VALUE_W-1:0]          csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [SLOT_W-1:0]           rsp_encoder_index,
   output logic [KIND_W-1:0]           rsp_event_kind,
   output logic signed [VALUE_W-1:0]   rsp_event_value,
   output logic [ELAPSED_W-1:0]        rsp_elapsed_since_turn,
   output logic                        rsp_is_last
);

   typedef struct packed {
      logic [SLOT_W-1:0]         enc;
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic [ELAPSED_W-1:0]      elapsed;
   } ebsv_item_type;

   // Configuration.
   logic signed [VALUE_W-1:0] value_min_ff;
   logic signed [VALUE_W-1:0] value_max_ff;

   // Frame being walked.
   logic [SCAN_W-1:0] frame_ff;
   logic [TIME_W-1:0] now_ff;
   logic [SLOT_W-1:0] slot_ff;

   // Per-slot and per-encoder state.
   logic [3:0]                prev_nib_ff  [NUM_ENC];
   logic                      phase_a_ff   [NUM_ENC];
   logic                      phase_b_ff   [NUM_ENC];
   logic                      lock_ff      [NUM_ENC];
   logic                      button_ff    [NUM_ENC];
   logic [TIME_W-1:0]         last_turn_ff [NUM_ENC];
   logic signed [VALUE_W-1:0] enc_value_ff [NUM_ENC];

   // Items of the current slot, the one-deep hold stage and the output register.
   ebsv_item_type btn_item_ff;
   ebsv_item_type rot_item_ff;
   logic          btn_pend_ff;
   logic          rot_pend_ff;
   ebsv_item_type hold_ff;
   logic          hold_valid_ff;
   ebsv_item_type out_ff;
   logic          out_valid_ff;
   logic          out_last_ff;

   logic [SLOT_W-1:0]         enc;
   logic [3:0]                nib;
   logic                      a_bit;
   logic                      b_bit;
   logic                      btn_bit;
   logic                      step_up;
   logic                      step_dn;
   logic                      lock_in;
   logic [TIME_W-1:0]         el;
   logic [ELAPSED_W-1:0]      el_rep;
   logic [4:0]                el_clamp;
   logic [3:0]                mag;
   logic signed [VALUE_W:0]   inc;
   logic signed [VALUE_W:0]   sum;
   logic signed [VALUE_W-1:0] value_in;
   ebsv_item_type             btn_item_in;
   ebsv_item_type             rot_item_in;
   ebsv_item_type             push_item;
   logic                      commit;

   assign enc     = enc_of_slot(slot_ff);
   assign nib     = frame_ff[{slot_ff, 2'b00} +: 4];
   assign btn_bit = nib[2];
   assign a_bit   = nib[1];
   assign b_bit   = nib[0];
   assign commit  = cmd.eval && (nib != prev_nib_ff[slot_ff]);

   // Quadrature decode at the detent: one step per detent until both phases drop.
   always_comb begin
      step_up = 1'b0;
      step_dn = 1'b0;
      lock_in = lock_ff[enc];
      if (a_bit && b_bit && !lock_ff[enc]) begin
         if (!phase_b_ff[enc]) begin
            step_dn = 1'b1;
            lock_in = 1'b1;
         end else if (!phase_a_ff[enc]) begin
            step_up = 1'b1;
            lock_in = 1'b1;
         end
      end
      if (!a_bit && !b_bit) begin
         lock_in = 1'b0;
      end
   end

   // Elapsed time, its saturated report and the velocity-scaled increment.
   always_comb begin
      el     = now_ff - last_turn_ff[enc];
      el_rep = (|el[TIME_W-1:ELAPSED_W]) ? {ELAPSED_W{1'b1}} : el[ELAPSED_W-1:0];
      if ((|el[TIME_W-1:5]) || (el[4:0] > VEL_SPAN)) begin
         el_clamp = VEL_SPAN;
      end else if (el[4:0] == 5'd0) begin
         el_clamp = 5'd1;
      end else begin
         el_clamp = el[4:0];
      end
      mag = vel_step(el_clamp);
      if (step_dn) begin
         inc = -$signed({{(VALUE_W-3){1'b0}}, mag});
      end else begin
         inc = $signed({{(VALUE_W-3){1'b0}}, mag});
      end
      sum = $signed({enc_value_ff[enc][VALUE_W-1], enc_value_ff[enc]}) + inc;
      if (sum < $signed({value_min_ff[VALUE_W-1], value_min_ff})) begin
         value_in = value_min_ff;
      end else if (sum > $signed({value_max_ff[VALUE_W-1], value_max_ff})) begin
         value_in = value_max_ff;
      end else begin
         value_in = sum[VALUE_W-1:0];
      end
   end

   always_comb begin
      btn_item_in.enc     = enc;
      btn_item_in.kind    = btn_bit ? KIND_RELEASE : KIND_PRESS;
      btn_item_in.value   = btn_bit ? RELEASE_VALUE : PRESS_VALUE;
      btn_item_in.elapsed = '0;
      rot_item_in.enc     = enc;
      rot_item_in.kind    = KIND_ROTATE;
      rot_item_in.value   = value_in;
      rot_item_in.elapsed = el_rep;
      push_item           = cmd.push_btn ? btn_item_ff : rot_item_ff;
   end

   always_comb begin
      sts.changed    = nib != prev_nib_ff[slot_ff];
      sts.btn_pend   = btn_pend_ff;
      sts.rot_pend   = rot_pend_ff;
      sts.hold_valid = hold_valid_ff;
      sts.out_free   = !out_valid_ff || rsp_ready;
      sts.can_push   = !hold_valid_ff || !out_valid_ff || rsp_ready;
      sts.last_slot  = (slot_ff == SLOT_W'(NUM_ENC - 1));
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff <= VALUE_MIN_RESET;
         value_max_ff <= VALUE_MAX_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VALUE_MIN: value_min_ff <= csr_wdata;
            CSR_VALUE_MAX: value_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame latch and slot counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.load) begin
         slot_ff <= '0;
      end else if (cmd.next_slot) begin
         slot_ff <= slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         frame_ff <= req_scan_bits;
         now_ff   <= req_now_ms;
      end
   end

   // State update for a slot whose nibble changed.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ENC; k++) begin
            prev_nib_ff[k]  <= 4'h0;
            phase_a_ff[k]   <= 1'b1;
            phase_b_ff[k]   <= 1'b1;
            lock_ff[k]      <= 1'b0;
            button_ff[k]    <= 1'b1;
            last_turn_ff[k] <= {TIME_W{1'b1}};
            enc_value_ff[k] <= '0;
         end
         btn_pend_ff <= 1'b0;
         rot_pend_ff <= 1'b0;
      end else if (commit) begin
         prev_nib_ff[slot_ff] <= nib;
         phase_a_ff[enc]      <= a_bit;
         phase_b_ff[enc]      <= b_bit;
         lock_ff[enc]         <= lock_in;
         button_ff[enc]       <= btn_bit;
         if (step_up || step_dn) begin
            last_turn_ff[enc] <= now_ff;
            enc_value_ff[enc] <= value_in;
         end
         btn_pend_ff <= (btn_bit != button_ff[enc]);
         rot_pend_ff <= step_up || step_dn;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         btn_item_ff <= btn_item_in;
         rot_item_ff <= rot_item_in;
      end
   end

   // Hold stage: an item goes out only once the next one, or the frame end, is known,
   // so that the last item of a frame can be flagged.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.push_btn || cmd.push_rot) begin
            hold_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
         if (((cmd.push_btn || cmd.push_rot) && hold_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_btn || cmd.push_rot) begin
         hold_ff <= push_item;
      end
      if (((cmd.push_btn || cmd.push_rot) && hold_valid_ff) || cmd.flush) begin
         out_ff      <= hold_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_encoder_index      = out_ff.enc;
   assign rsp_event_kind         = out_ff.kind;
   assign rsp_event_value        = out_ff.value;
   assign rsp_elapsed_since_turn = out_ff.elapsed;
   assign rsp_is_last            = out_last_ff;

endmodule

/* sv/encoder_bank_scan_velocity.sv */
// Top level of the encoder bank scanner with velocity-scaled rotation values.
//
// A scan frame item enters on the req_ channel: sixteen 4-bit slots of button
// and quadrature phase bits plus the current time in milliseconds. Each slot
// belongs to one encoder through a fixed wiring table. A slot whose nibble
// changed since the last frame is decoded, and it may give a button press or
// release item and then a rotation item, which leave in that order on the
// rsp_ channel. The last item of a frame carries rsp_is_last; a frame with no
// change gives no item. The csr_ port writes the shared lower and upper clamp
// of encoder values. Write it only while the block idles; this is not enforced.
//
// The sequencer walks unchanged slots one per cycle; a changed slot also passes
// the button and rotation push states, which wait while the hold stage and output
// register are full. req_ready rises again once the walk and final flush are done.
// One item is held back until the next item or the end of the frame is known, so
// a decoded item passes the item, hold and output registers, and the last item of
// a frame appears only once the walk has passed the final slot. When the receiver
// stalls, the output register and the hold stage fill and the slot walk waits; no
// item is lost. Reset clears all per-encoder state, the clamps (0 and 127) and both
// channels at once; there is no clearing pass.
module encoder_bank_scan_velocity import ebsv_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SCAN_W-1:0]           req_scan_bits,
   input  logic [TIME_W-1:0]           req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [SLOT_W-1:0]           rsp_encoder_index,
   output logic [KIND_W-1:0]           rsp_event_kind,
   output logic signed [VALUE_W-1:0]   rsp_event_value,
   output logic [ELAPSED_W-1:0]        rsp_elapsed_since_turn,
   output logic                        rsp_is_last,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VALUE_W-1:0]          csr_wdata
);

   ebsv_cmd_type cmd;
   ebsv_sts_type sts;

   // The sequencer owns the slot walk and the input handshake.
   ebsv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds all encoder state and the result registers.
   ebsv_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_scan_bits          (req_scan_bits),
      .req_now_ms             (req_now_ms),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_encoder_index      (rsp_encoder_index),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_event_value        (rsp_event_value),
      .rsp_elapsed_since_turn (rsp_elapsed_since_turn),
      .rsp_is_last            (rsp_is_last)
   );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the encoder bank scanner with velocity-scaled rotation values.
module tb_top;
   import ebsv_pkg::*;

   // Run limits. The slowest correct run is far below CYCLE_LIMIT. That run has every
   // frame at its longest slot walk plus a sender gap, up to 32 items per frame paced
   // by the slowest receiver pattern, the long hold-off, and the quiet periods around
   // each clamp change.
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int QUIET_CYCLES      = 64;    // longer than one full frame walk
   localparam int HOLD_AFTER_FRAMES = 40;    // frame count that starts the long stall
   localparam int HOLD_CYCLES       = 400;
   localparam int MAX_REPORTS       = 10;

   // Velocity curve: the elapsed time is clamped to 1..25 ms. The step is then
   // 2f-1 with f = (625 - t*t) / 150 + 1.
   localparam int VEL_KNEE_MS = 25;
   localparam int VEL_DIVISOR = 150;

   // How a row of the directed table is checked.
   localparam int BY_PREDICTOR = -1;   // expectations come from the predictor
   localparam int EXPECT_NONE  = 0;    // the frame must produce no item
   localparam int EXPECT_ONE   = 1;    // exactly the typed-in item

   // Wiring of scan slots to encoder numbers, as the board routes them.
   localparam logic [SLOT_W-1:0] SLOT_WIRING [NUM_ENC] =
      '{4'd14, 4'd15, 4'd10, 4'd11, 4'd6, 4'd7, 4'd2, 4'd3,
        4'd12, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd0, 4'd1};

   typedef struct packed {
      logic [SLOT_W-1:0]    enc;
      logic [KIND_W-1:0]    kind;
      logic [VALUE_W-1:0]   value;
      logic [ELAPSED_W-1:0] elapsed;
      logic                 last;
   } scan_event_type;

   localparam scan_event_type NO_EVENT = '0;

   typedef struct {
      logic [SCAN_W-1:0] scan;
      logic [TIME_W-1:0] now;
      int                check;
      scan_event_type    typed;
   } scan_row_type;

   // The receiver picks one of these pacing patterns for a while, then another one.
   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE_STALL, RX_TRICKLE} rx_pace_type;

   // Clock, reset and the block's inputs. Every input is known from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic [SCAN_W-1:0]    req_scan_bits = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_VALUE_MIN;
   logic [VALUE_W-1:0]   csr_wdata = '0;

   logic                       req_ready;
   logic                       rsp_valid;
   logic [SLOT_W-1:0]          rsp_encoder_index;
   logic [KIND_W-1:0]          rsp_event_kind;
   logic signed [VALUE_W-1:0]  rsp_event_value;
   logic [ELAPSED_W-1:0]       rsp_elapsed_since_turn;
   logic                       rsp_is_last;

   encoder_bank_scan_velocity dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_scan_bits          (req_scan_bits),
      .req_now_ms             (req_now_ms),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_encoder_index      (rsp_encoder_index),
      .rsp_event_kind         (rsp_event_kind),
      .rsp_event_value        (rsp_event_value),
      .rsp_elapsed_since_turn (rsp_elapsed_since_turn),
      .rsp_is_last            (rsp_is_last),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Predictor state. It mirrors the block's per-slot and per-encoder memory and the
   // two clamp registers, all at their reset values.
   logic [SLOT_W-1:0]         seen_nibble [NUM_ENC] = '{default: '0};
   logic                      last_pha    [NUM_ENC] = '{default: 1'b1};
   logic                      last_phb    [NUM_ENC] = '{default: 1'b1};
   logic                      detent_held [NUM_ENC] = '{default: 1'b0};
   logic                      btn_level   [NUM_ENC] = '{default: 1'b1};
   logic [TIME_W-1:0]         turn_stamp  [NUM_ENC] = '{default: '1};
   logic signed [VALUE_W-1:0] enc_value   [NUM_ENC] = '{default: '0};
   logic signed [VALUE_W-1:0] clamp_lo = VALUE_MIN_RESET;
   logic signed [VALUE_W-1:0] clamp_hi = VALUE_MAX_RESET;

   // Items of the frame being decoded, and the items still owed by the block in order.
   scan_event_type frame_events [2*NUM_ENC];
   int             frame_event_count;
   scan_event_type awaited_events [$];

   int mismatch_count  = 0;
   int frames_accepted = 0;

   // Sender state: the current scan picture that random frames evolve from, the per-slot
   // turning direction, the running millisecond clock and the burst length left.
   logic [SCAN_W-1:0] scan_now = '0;
   bit                walk_up [NUM_ENC] = '{default: 1'b1};
   logic [TIME_W-1:0] clock_ms = '0;
   int                burst_left = 0;

   // Receiver pacing state, owned by the pacing process alone.
   rx_pace_type rx_pace   = RX_STEADY;
   int          pace_left = 0;
   int          pace_tick = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;

   function automatic scan_event_type scan_event(input logic [SLOT_W-1:0] enc,
                                                 input logic [KIND_W-1:0] kind,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [ELAPSED_W-1:0] elapsed,
                                                 input logic last);
      scan_event_type ev;
      ev.enc     = enc;
      ev.kind    = kind;
      ev.value   = value;
      ev.elapsed = elapsed;
      ev.last    = last;
      return ev;
   endfunction

   function automatic scan_row_type plan_row(input logic [SCAN_W-1:0] scan,
                                             input logic [TIME_W-1:0] now,
                                             input int check, input scan_event_type typed);
      scan_row_type row;
      row.scan  = scan;
      row.now   = now;
      row.check = check;
      row.typed = typed;
      return row;
   endfunction

   // One quarter step along the quadrature cycle. Turning up runs 11, 10, 00, 01 and back
   // to 11, which the block counts as +1 at the detent. Turning down runs the other way.
   function automatic logic [1:0] gray_step(input logic [1:0] ab, input bit up);
      case (ab)
         2'b11:   return up ? 2'b10 : 2'b01;
         2'b10:   return up ? 2'b00 : 2'b11;
         2'b00:   return up ? 2'b01 : 2'b10;
         default: return up ? 2'b11 : 2'b00;
      endcase
   endfunction

   // Decodes one scan frame against the predictor state and fills frame_events with the
   // items that the block must send for it, in order, with the last one marked.
   task automatic decode_scan_frame(input logic [SCAN_W-1:0] scan,
                                    input logic [TIME_W-1:0] now);
      logic [SLOT_W-1:0]         nib;
      logic [SLOT_W-1:0]         enc;
      logic                      btn;
      logic                      pha;
      logic                      phb;
      int                        step;
      logic [TIME_W-1:0]         gap_ms;
      int                        span;
      int                        gain;
      longint                    total;
      logic signed [VALUE_W-1:0] rot_value;
      frame_event_count = 0;
      for (int j = 0; j < NUM_ENC; j++) begin
         nib = scan[SLOT_W*j +: SLOT_W];
         if (nib != seen_nibble[j]) begin
            seen_nibble[j] = nib;
            enc  = SLOT_WIRING[j];
            btn  = nib[2];
            pha  = nib[1];
            phb  = nib[0];
            step = 0;
            // One count per detent. The lock is released only by passing through 00.
            if (pha && phb && !detent_held[enc]) begin
               if (!last_phb[enc]) begin
                  step = -1;
               end else if (!last_pha[enc]) begin
                  step = 1;
               end
               if (step != 0) begin
                  detent_held[enc] = 1'b1;
               end
            end
            if (!pha && !phb) begin
               detent_held[enc] = 1'b0;
            end
            last_pha[enc] = pha;
            last_phb[enc] = phb;

            if (btn != btn_level[enc]) begin
               btn_level[enc] = btn;
               frame_events[frame_event_count] = btn ?
                  scan_event(enc, KIND_RELEASE, RELEASE_VALUE, '0, 1'b0) :
                  scan_event(enc, KIND_PRESS, PRESS_VALUE, '0, 1'b0);
               frame_event_count++;
            end

            if (step != 0) begin
               gap_ms = now - turn_stamp[enc];
               turn_stamp[enc] = now;
               if (gap_ms > VEL_KNEE_MS) begin
                  span = VEL_KNEE_MS;
               end else if (gap_ms == 0) begin
                  span = 1;
               end else begin
                  span = int'(gap_ms);
               end
               gain  = 2 * ((VEL_KNEE_MS * VEL_KNEE_MS - span * span) / VEL_DIVISOR + 1) - 1;
               total = longint'(enc_value[enc]) + longint'(step * gain);
               // When the clamps cross, a sum below the lower clamp gives it; any other sum gives the upper one.
               if (total < longint'(clamp_lo)) begin
                  rot_value = clamp_lo;
               end else if (total > longint'(clamp_hi)) begin
                  rot_value = clamp_hi;
               end else begin
                  rot_value = total[VALUE_W-1:0];
               end
               enc_value[enc] = rot_value;
               frame_events[frame_event_count] = scan_event(enc, KIND_ROTATE, rot_value,
                  (gap_ms > 32'hFFFF) ? 16'hFFFF : gap_ms[ELAPSED_W-1:0], 1'b0);
               frame_event_count++;
            end
         end
      end
      if (frame_event_count > 0) begin
         frame_events[frame_event_count-1].last = 1'b1;
      end
   endtask

   // Offers one frame and holds it until it is accepted. Then it books the expected
   // items and, at the end of a burst, drops valid for a random gap.
   task automatic offer_frame(input logic [SCAN_W-1:0] scan, input logic [TIME_W-1:0] now,
                              input int check, input scan_event_type typed,
                              input bit final_item);
      req_valid     <= 1'b1;
      req_scan_bits <= scan;
      req_now_ms    <= now;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      // The predictor always runs so that its state follows the block. Typed rows
      // replace its output with the values written in the table.
      decode_scan_frame(scan, now);
      if (check == BY_PREDICTOR) begin
         for (int i = 0; i < frame_event_count; i++) begin
            awaited_events.push_back(frame_events[i]);
         end
      end else if (check == EXPECT_ONE) begin
         awaited_events.push_back(typed);
      end
      frames_accepted++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (final_item || burst_left == 0) begin
         req_valid <= 1'b0;
         if (!final_item) begin
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         // Now and then a long burst gives a stretch with no sender idling.
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 12);
      end
   endtask

   // Lets the block drain: all owed items have arrived, and a frame with no change
   // that is still being walked has had time to finish.
   task automatic wait_for_quiet();
      while (awaited_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Writes both clamps in back-to-back cycles. The write enable stays high across both
   // writes, so it is never lowered and raised again between them.
   task automatic set_clamps(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_VALUE_MIN;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_index <= CSR_VALUE_MAX;
      csr_wdata <= hi;
      @(posedge clock);
      csr_write_en <= 1'b0;
      clamp_lo = lo;
      clamp_hi = hi;
      @(posedge clock);
   endtask

   // Builds the next random frame from the current scan picture. Most frames are
   // proper quadrature motion with random button and spare-bit flips. The others are
   // raw noise, repeats with no change, or broken phase jumps.
   task automatic next_scan_frame(input int step_max, output logic [SCAN_W-1:0] scan);
      int          pick;
      logic [3:0]  nib;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         scan_now = {$urandom, $urandom};
      end else if (pick == 2) begin
         // Same picture again: the block must stay silent.
      end else begin
         for (int j = 0; j < NUM_ENC; j++) begin
            nib = scan_now[SLOT_W*j +: SLOT_W];
            if (pick == 3) begin
               if ($urandom_range(0, 2) == 0) begin
                  nib[1:0] = nib[1:0] ^ 2'b11;
               end
            end else begin
               if ($urandom_range(0, 15) == 0) begin
                  walk_up[j] = !walk_up[j];
               end
               if ($urandom_range(0, 2) == 0) begin
                  nib[1:0] = gray_step(nib[1:0], walk_up[j]);
               end
               if ($urandom_range(0, 11) == 0) begin
                  nib[2] = !nib[2];
               end
               if ($urandom_range(0, 23) == 0) begin
                  nib[3] = !nib[3];
               end
            end
            scan_now[SLOT_W*j +: SLOT_W] = nib;
         end
      end
      // Time moves in small steps, with rare jumps anywhere on the 32-bit circle.
      if ($urandom_range(0, 24) == 0) begin
         clock_ms = $urandom;
      end else begin
         clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      scan = scan_now;
   endtask

   task automatic run_random_phase(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                                   input int frames, input int step_max);
      logic [SCAN_W-1:0] scan;
      wait_for_quiet();
      set_clamps(lo, hi);
      for (int k = 0; k < frames; k++) begin
         next_scan_frame(step_max, scan);
         offer_frame(scan, clock_ms, BY_PREDICTOR, NO_EVENT, k == frames - 1);
      end
   endtask

   task automatic report_mismatch(input string what, input scan_event_type want,
                                  input scan_event_type got);
      if (mismatch_count < MAX_REPORTS) begin
         $display("%s at %0t: expected enc=%0d kind=%0d value=%0d elapsed=%0d last=%0d,",
                  what, $time, want.enc, want.kind, $signed(want.value), want.elapsed,
                  want.last,
                  " got enc=%0d kind=%0d value=%0d elapsed=%0d last=%0d",
                  got.enc, got.kind, $signed(got.value), got.elapsed, got.last);
      end
      mismatch_count++;
   endtask

   // Result checker. A handshake is taken from the values that stood before the edge.
   // Each item is matched against the oldest expectation, field by field.
   always @(posedge clock) begin : result_check
      scan_event_type got;
      scan_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = scan_event(rsp_encoder_index, rsp_event_kind, rsp_event_value,
                          rsp_elapsed_since_turn, rsp_is_last);
         if (awaited_events.size() == 0) begin
            report_mismatch("item with nothing expected", NO_EVENT, got);
         end else begin
            want = awaited_events.pop_front();
            if (got.enc !== want.enc || got.kind !== want.kind || got.value !== want.value
                || got.elapsed !== want.elapsed || got.last !== want.last) begin
               report_mismatch("item mismatch", want, got);
            end
         end
      end
   end

   // Receiver pacing. It switches at random between steady, coin-flip, sparse-stall and
   // trickle patterns. Once, after enough frames have gone in, it holds off for a long
   // stretch while the sender keeps offering. The output and hold stages then fill, and
   // req_ready has to drop.
   always @(posedge clock) begin : receiver_pacing
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && frames_accepted >= HOLD_AFTER_FRAMES) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            rx_pace   = rx_pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(32, 160);
         end
         pace_left--;
         pace_tick++;
         case (rx_pace)
            RX_STEADY: begin
               rsp_ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
            end
            RX_SPARSE_STALL: begin
               rsp_ready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
               rsp_ready <= (pace_tick % 6 == 0);
            end
         endcase
      end
   end

   // Cycle counter that ends a run which hangs.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("encoder_bank_scan_velocity test failed");
      $finish;
   end

   initial begin : stimulus
      scan_row_type plan_rows [$];

      // Directed table. Only slot 0 moves at first. It feeds encoder 14, which starts
      // released with both phases high, so a single turn-up needs 01 and then 11.
      // Time 0x8000_0000 puts the first turn far from the all-ones reset stamp.
      // Frame of all zeros: the same as the reset picture, so no item.
      plan_rows.push_back(plan_row(64'h0, 32'h0, EXPECT_NONE, NO_EVENT));
      // Phase 01 with the button still released: the slot changes, but nothing is sent.
      plan_rows.push_back(plan_row(64'h5, 32'h8000_0000, EXPECT_NONE, NO_EVENT));
      // Detent reached from 01 counts up by one step. The elapsed time saturates, so the
      // slowest step size of 1 applies.
      plan_rows.push_back(plan_row(64'h7, 32'h8000_0000, EXPECT_ONE,
                                   scan_event(4'd14, KIND_ROTATE, 32'sd1, 16'hFFFF, 1'b1)));
      // Only the spare bit 3 flips, and the detent lock blocks a second count.
      plan_rows.push_back(plan_row(64'hF, 32'h8000_0000, EXPECT_NONE, NO_EVENT));
      // Button pressed (bit 2 low).
      plan_rows.push_back(plan_row(64'h3, 32'h8000_0000, EXPECT_ONE,
                                   scan_event(4'd14, KIND_PRESS, PRESS_VALUE, '0, 1'b1)));
      // Button released.
      plan_rows.push_back(plan_row(64'h7, 32'h8000_0000, EXPECT_ONE,
                                   scan_event(4'd14, KIND_RELEASE, RELEASE_VALUE, '0, 1'b1)));
      // Through 00, which frees the lock, then 10.
      plan_rows.push_back(plan_row(64'h4, 32'h8000_0000, EXPECT_NONE, NO_EVENT));
      plan_rows.push_back(plan_row(64'h6, 32'h8000_0000, EXPECT_NONE, NO_EVENT));
      // Detent reached from 10 counts down with zero elapsed time, the fastest step of
      // 9. The lower clamp then holds the value at 0.
      plan_rows.push_back(plan_row(64'h7, 32'h8000_0000, EXPECT_ONE,
                                   scan_event(4'd14, KIND_ROTATE, 32'sd0, 16'h0, 1'b1)));
      // Press and turn in the same slot: the button item comes first.
      plan_rows.push_back(plan_row(64'h4, 32'h8000_0000, BY_PREDICTOR, NO_EVENT));
      plan_rows.push_back(plan_row(64'h5, 32'h8000_0000, BY_PREDICTOR, NO_EVENT));
      plan_rows.push_back(plan_row(64'h3, 32'h8000_0001, BY_PREDICTOR, NO_EVENT));
      // A turn exactly 65535 ms after the last one reaches the saturation edge.
      plan_rows.push_back(plan_row(64'h4, 32'h8001_0000, BY_PREDICTOR, NO_EVENT));
      plan_rows.push_back(plan_row(64'h5, 32'h8001_0000, BY_PREDICTOR, NO_EVENT));
      plan_rows.push_back(plan_row(64'h7, 32'h8001_0000, BY_PREDICTOR, NO_EVENT));
      // All sixteen slots at once. The clock wraps back to a small value. The 11 frame
      // gives a press and a turn on every encoder, 32 items in all.
      plan_rows.push_back(plan_row(64'h4444_4444_4444_4444, 32'h8001_0010, BY_PREDICTOR,
                                   NO_EVENT));
      plan_rows.push_back(plan_row(64'h5555_5555_5555_5555, 32'h8001_0010, BY_PREDICTOR,
                                   NO_EVENT));
      plan_rows.push_back(plan_row(64'h3333_3333_3333_3333, 32'h0000_0002, BY_PREDICTOR,
                                   NO_EVENT));
      plan_rows.push_back(plan_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0002, BY_PREDICTOR,
                                   NO_EVENT));
      plan_rows.push_back(plan_row(64'h0, 32'h0000_0002, BY_PREDICTOR, NO_EVENT));
      plan_rows.push_back(plan_row(64'h2222_2222_2222_2222, 32'h0000_0002, BY_PREDICTOR,
                                   NO_EVENT));
      plan_rows.push_back(plan_row(64'hBBBB_BBBB_BBBB_BBBB, 32'h0000_0002, BY_PREDICTOR,
                                   NO_EVENT));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < plan_rows.size(); i++) begin
         offer_frame(plan_rows[i].scan, plan_rows[i].now, plan_rows[i].check,
                     plan_rows[i].typed, i == plan_rows.size() - 1);
      end
      scan_now = plan_rows[plan_rows.size()-1].scan;
      clock_ms = plan_rows[plan_rows.size()-1].now;

      // Random phases. Each sets both clamps while the block is quiet: the reset
      // window, the full 32-bit range, a narrow window, crossed clamps, windows at
      // both ends of the range where the sum would overflow 32 bits, and random
      // values. Time steps vary so that every velocity band is reached.
      run_random_phase(VALUE_MIN_RESET, VALUE_MAX_RESET, 30, 8);
      run_random_phase(32'h8000_0000, 32'h7FFF_FFFF, 30, 30);
      run_random_phase(-32'sd20, 32'sd20, 30, 3);
      run_random_phase(32'sd50, -32'sd50, 20, 12);
      run_random_phase(32'h7FFF_FFD0, 32'h7FFF_FFFF, 25, 2);
      run_random_phase(32'h8000_0000, 32'h8000_0030, 25, 6);
      run_random_phase($urandom, $urandom, 20, 20);

      wait_for_quiet();
      if (mismatch_count == 0) begin
         $display("encoder_bank_scan_velocity test passed");
      end else begin
         $display("encoder_bank_scan_velocity test failed");
      end
      $finish;
   end

endmodule
